// ===== rtl/tcw_pkg.sv =====
// Shared types and constants for the text console character writer.
`default_nettype none

package tcw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_POST,
    ST_READ,
    ST_COPY,
    ST_COPY_END,
    ST_FILL,
    ST_DONE
  } state_e;

  localparam logic [7:0]  CH_BACKSPACE = 8'h08;
  localparam logic [7:0]  CH_TAB       = 8'h09;
  localparam logic [7:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CH_RETURN    = 8'h0D;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  CH_LAST_PRT  = 8'h7F;

  localparam logic [7:0]  ATTR_RESET   = 8'h0F;
  localparam logic [15:0] CELL_RESET   = 16'h0F20;

  localparam logic        REG_TEXT_ATTR = 1'b0;

  localparam int unsigned LOC_W  = 11;
  localparam int unsigned DATA_W = 16;

endpackage

`default_nettype wire

// ===== rtl/tcw_if.sv =====
// Command and result channel interfaces of the text console character writer.
`default_nettype none

interface tcw_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  char_code;
  logic [3:0]  clear_background;
  logic [3:0]  clear_foreground;
  logic [10:0] cell_index;

  modport source (
    output valid, command, char_code, clear_background, clear_foreground, cell_index,
    input  ready
  );

  modport sink (
    input  valid, command, char_code, clear_background, clear_foreground, cell_index,
    output ready
  );
endinterface

interface tcw_res_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_location;
  logic [15:0] read_data;

  modport source (
    output valid, cursor_location, read_data,
    input  ready
  );

  modport sink (
    input  valid, cursor_location, read_data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/text_console_char_writer.sv =====
// Top level of the text console character writer: screen memory, cursor and sequencer.
//
//   channel   | dir | handshake     | payload
//   ----------+-----+---------------+-------------------------------------------------
//   cmd_i     | in  | valid/ready   | command, char_code, clear_background/foreground,
//             |     |               | cell_index
//   res_o     | out | valid/ready   | cursor_location, read_data
//   APB       | in  | psel/penable  | text_attribute at byte address 0
//
// A put or a read inside the screen passes through ST_EXEC, then ST_POST or ST_READ, then
// ST_DONE, which loads the output register behind res_o.valid; an unused command or a read
// beyond the screen skips the middle state. A put that scrolls copies the rows up and then
// fills the last row, and a clear fills every cell, both through the single write port of
// the screen memory, one cell per cycle. After reset a clearing pass fills the screen
// before cmd_i.ready rises. A command is accepted while a result still waits in the output
// register; the sequencer holds its result until that register frees.
`default_nettype none

module text_console_char_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  tcw_cmd_if.sink      cmd_i,
  tcw_res_if.source    res_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire  [2:0]   paddr,
  input  wire  [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW     = $clog2(ROWS + 1);
  localparam int MW     = $clog2(TAB_WIDTH);
  localparam int LW     = (AW > LOC_W) ? AW : LOC_W;

  logic [DATA_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] rdata_q;

  state_e            state_q, state_d;
  logic [7:0]        attr_q;
  logic [1:0]        cmd_q, cmd_d;
  logic [7:0]        ch_q, ch_d;
  logic [3:0]        bg_q, bg_d;
  logic [3:0]        fg_q, fg_d;
  logic [10:0]       idx_q, idx_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [MW-1:0]     mod_q, mod_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;
  logic [DATA_W-1:0] fill_val_q, fill_val_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              out_valid_q, out_valid_d;
  logic [LOC_W-1:0]  out_loc_q, out_loc_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;

  logic              printable;
  logic              idx_ok;
  logic              col_wrap;
  logic [RW-1:0]     row_next;
  logic              scroll;
  logic              out_free;
  logic [AW-1:0]     cell_addr;
  logic [LW-1:0]     loc_full;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEXT_ATTR) ? {24'b0, attr_q} : 32'b0;

  assign cmd_i.ready           = (state_q == ST_IDLE);
  assign res_o.valid           = out_valid_q;
  assign res_o.cursor_location = out_loc_q;
  assign res_o.read_data       = out_data_q;

  assign printable = (ch_q >= CH_SPACE) && (ch_q <= CH_LAST_PRT);
  assign idx_ok    = (32'(idx_q) < 32'(CELLS));
  assign col_wrap  = (32'(col_q) >= 32'(COLUMNS));
  assign row_next  = col_wrap ? row_q + RW'(1) : row_q;
  assign scroll    = (32'(row_next) == 32'(ROWS));
  assign out_free  = !out_valid_q || res_o.ready;
  assign cell_addr = AW'(AW'(row_q) * AW'(COLUMNS) + AW'(col_q));
  assign loc_full  = LW'(row_q) * LW'(COLUMNS) + LW'(col_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      attr_q      <= ATTR_RESET;
      col_q       <= '0;
      row_q       <= '0;
      mod_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      mod_q       <= mod_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && (paddr[2] == REG_TEXT_ATTR)) begin
        attr_q <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    ch_q        <= ch_d;
    bg_q        <= bg_d;
    fg_q        <= fg_d;
    idx_q       <= idx_d;
    pend_addr_q <= pend_addr_d;
    fill_val_q  <= fill_val_d;
    data_q      <= data_d;
    out_loc_q   <= out_loc_d;
    out_data_q  <= out_data_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (32'(ptr_q) == CELLS - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_i.valid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cmd_q)
          CMD_PUT:   state_d = ST_POST;
          CMD_CLEAR: state_d = ST_FILL;
          CMD_READ:  state_d = idx_ok ? ST_READ : ST_DONE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_POST: begin
        state_d = scroll ? ST_COPY : ST_DONE;
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_COPY: begin
        if (32'(ptr_q) == COPY_N - 1) state_d = ST_COPY_END;
      end
      ST_COPY_END: begin
        state_d = ST_FILL;
      end
      ST_FILL: begin
        if (32'(ptr_q) == CELLS - 1) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d       = cmd_q;
    ch_d        = ch_q;
    bg_d        = bg_q;
    fg_d        = fg_q;
    idx_d       = idx_q;
    col_d       = col_q;
    row_d       = row_q;
    mod_d       = mod_q;
    ptr_d       = ptr_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    fill_val_d  = fill_val_q;
    data_d      = data_q;
    out_valid_d = out_valid_q;
    out_loc_d   = out_loc_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = fill_val_q;
    mem_raddr   = AW'(idx_q);

    if (out_valid_q && res_o.ready) out_valid_d = 1'b0;

    if (pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr_q;
      mem_wdata = rdata_q;
    end

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = CELL_RESET;
        ptr_d     = (32'(ptr_q) == CELLS - 1) ? '0 : ptr_q + AW'(1);
      end
      ST_IDLE: begin
        cmd_d = cmd_i.command;
        ch_d  = cmd_i.char_code;
        bg_d  = cmd_i.clear_background;
        fg_d  = cmd_i.clear_foreground;
        idx_d = cmd_i.cell_index;
      end
      ST_EXEC: begin
        data_d = '0;
        unique case (cmd_q)
          CMD_PUT: begin
            if (ch_q == CH_BACKSPACE) begin
              if (col_q != '0) begin
                col_d = col_q - CW'(1);
                mod_d = (mod_q == '0) ? MW'(TAB_WIDTH - 1) : mod_q - MW'(1);
              end
            end else if (ch_q == CH_TAB) begin
              col_d = col_q + CW'(TAB_WIDTH) - CW'(mod_q);
              mod_d = '0;
            end else if (ch_q == CH_RETURN) begin
              col_d = '0;
              mod_d = '0;
            end else if (ch_q == CH_NEWLINE) begin
              col_d = '0;
              mod_d = '0;
              row_d = row_q + RW'(1);
            end else if (printable) begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr;
              mem_wdata = {attr_q, ch_q};
              col_d     = col_q + CW'(1);
              mod_d     = (32'(mod_q) == TAB_WIDTH - 1) ? '0 : mod_q + MW'(1);
            end
          end
          CMD_CLEAR: begin
            fill_val_d = {bg_q, fg_q, CH_SPACE};
            ptr_d      = '0;
            col_d      = '0;
            row_d      = '0;
            mod_d      = '0;
          end
          default: ;
        endcase
      end
      ST_POST: begin
        if (col_wrap) begin
          col_d = '0;
          mod_d = '0;
        end
        row_d = row_next;
        if (scroll) begin
          row_d      = RW'(ROWS - 1);
          ptr_d      = '0;
          fill_val_d = {attr_q, CH_SPACE};
        end
      end
      ST_READ: begin
        data_d = rdata_q;
      end
      ST_COPY: begin
        mem_raddr   = ptr_q + AW'(COLUMNS);
        pend_d      = 1'b1;
        pend_addr_d = ptr_q;
        ptr_d       = ptr_q + AW'(1);
      end
      ST_COPY_END: ;
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = fill_val_q;
        ptr_d     = (32'(ptr_q) == CELLS - 1) ? '0 : ptr_q + AW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_loc_d   = loc_full[LOC_W-1:0];
          out_data_d  = data_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
